// ===== design/mxt_pkg.sv =====
// Shared types and constants for the maximum subarray XOR trie unit.
// No dependencies; every other design file refers to this package by scoped name.
`default_nettype none

package mxt_pkg;

    // Port width of the element and result data fields.
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO_ISSUE,
        ST_ZERO_WALK,
        ST_PFX_ISSUE,
        ST_PFX_WALK,
        ST_QRY_ISSUE,
        ST_QRY_WALK,
        ST_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;      // take the input request
        logic set_prefix;  // fold the element into the running prefix
        logic ins_begin;   // start an insert walk at the root
        logic ins_step;    // one insert level
        logic qry_begin;   // start a query walk at the root
        logic qry_step;    // one query level
        logic out_load;    // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic start_now;   // the request opens a new array
        logic full_now;    // item budget of the current array is used up
        logic ins_done;    // insert walk finishes this cycle
        logic qry_done;    // query walk finishes this cycle
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/max_xor_subarray_trie_unit.sv =====
// Top level of the maximum subarray XOR unit: binary trie of prefix XORs.
// Depends on mxt_pkg, mxt_ctrl and mxt_datapath.
//
//  channel  | dir | handshake          | tdata             | tuser
//  ---------+-----+--------------------+-------------------+-------------
//  s_ input | in  | s_tvalid/s_tready  | [31:0] element    | [0] first
//  m_ output| out | m_tvalid/m_tready  | [31:0] best_xor   | [0] full_res
//
// An ordinary request runs one insert walk and one query walk, each an issue
// step followed by one node-memory read per trie level.
// A request that opens an array adds a zero insert walk before these.
// A request past the MAX_ITEMS budget changes nothing.
// Reset is synchronous, active low; no memory clearing pass is needed, the
// first request after reset always opens an array.
// A stalled result sits in the output register while the next request is taken.
`default_nettype none

module max_xor_subarray_trie_unit #(
    parameter int unsigned WIDTH     = 32,
    parameter int unsigned MAX_ITEMS = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [mxt_pkg::DATA_W-1:0] s_tdata,   // [31:0] element
    input  wire logic                       s_tuser,   // [0] first
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [mxt_pkg::DATA_W-1:0]      m_tdata,   // [31:0] best_xor
    output logic                            m_tuser    // [0] full_res
);

    mxt_pkg::ctrl_cmd_t  cmd;
    mxt_pkg::dp_status_t status;

    // Sequence each request through insert and query walks.
    mxt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the trie, prefix, best value and the result register.
    mxt_datapath #(
        .WIDTH     (WIDTH),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_element  (s_tdata),
        .s_first    (s_tuser),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_best_xor (m_tdata),
        .m_full_res (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/mxt_ctrl.sv =====
// Sequencing state machine of the trie unit: accept, zero insert, prefix insert,
// query, result hand-off. Depends on mxt_pkg.
`default_nettype none

module mxt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mxt_pkg::dp_status_t status,
    output mxt_pkg::ctrl_cmd_t      cmd
);

    mxt_pkg::state_t state_reg;
    mxt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mxt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            mxt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.start_now) begin
                        state_next = mxt_pkg::ST_ZERO_ISSUE;
                    end else if (status.full_now) begin
                        state_next = mxt_pkg::ST_DONE;
                    end else begin
                        state_next = mxt_pkg::ST_PFX_ISSUE;
                    end
                end
            end
            mxt_pkg::ST_ZERO_ISSUE: begin
                cmd.ins_begin = 1'b1;
                state_next    = mxt_pkg::ST_ZERO_WALK;
            end
            mxt_pkg::ST_ZERO_WALK: begin
                cmd.ins_step = 1'b1;
                if (status.ins_done) begin
                    state_next = mxt_pkg::ST_PFX_ISSUE;
                end
            end
            mxt_pkg::ST_PFX_ISSUE: begin
                cmd.set_prefix = 1'b1;
                cmd.ins_begin  = 1'b1;
                state_next     = mxt_pkg::ST_PFX_WALK;
            end
            mxt_pkg::ST_PFX_WALK: begin
                cmd.ins_step = 1'b1;
                if (status.ins_done) begin
                    state_next = mxt_pkg::ST_QRY_ISSUE;
                end
            end
            mxt_pkg::ST_QRY_ISSUE: begin
                cmd.qry_begin = 1'b1;
                state_next    = mxt_pkg::ST_QRY_WALK;
            end
            mxt_pkg::ST_QRY_WALK: begin
                cmd.qry_step = 1'b1;
                if (status.qry_done) begin
                    state_next = mxt_pkg::ST_DONE;
                end
            end
            mxt_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mxt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mxt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mxt_datapath.sv =====
// Datapath of the trie unit: node memory, walk registers, prefix, best value
// and the output register. Depends on mxt_pkg.
`default_nettype none

module mxt_datapath #(
    parameter int unsigned WIDTH     = 32,
    parameter int unsigned MAX_ITEMS = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [mxt_pkg::DATA_W-1:0]  s_element,
    input  wire logic                        s_first,
    input  wire mxt_pkg::ctrl_cmd_t          cmd,
    output mxt_pkg::dp_status_t              status,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [mxt_pkg::DATA_W-1:0]       m_best_xor,
    output logic                             m_full_res
);

    localparam int unsigned NODE_DEPTH = 1 + WIDTH * (MAX_ITEMS + 1);
    localparam int unsigned IDXW       = $clog2(NODE_DEPTH);
    localparam int unsigned CNTW       = $clog2(NODE_DEPTH + 1);
    localparam int unsigned LVLW       = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int unsigned ITW        = $clog2(MAX_ITEMS + 1);

    // Entry layout: {child for bit one, child for bit zero}; zero means no child.
    logic [2*IDXW-1:0] node_mem [NODE_DEPTH];
    logic [2*IDXW-1:0] rd_data_reg;
    logic [IDXW-1:0]   rd_addr;
    logic              wr_en;
    logic [2*IDXW-1:0] wr_data;

    logic              started_reg;
    logic              fresh_reg;
    logic [CNTW-1:0]   nodes_used_reg;
    logic [ITW-1:0]    items_reg;
    logic [WIDTH-1:0]  elem_reg;
    logic [WIDTH-1:0]  prefix_reg;
    logic [WIDTH-1:0]  key_reg;
    logic [WIDTH-1:0]  best_reg;
    logic [WIDTH-1:0]  acc_reg;
    logic [IDXW-1:0]   cur_reg;
    logic [LVLW-1:0]   level_reg;
    logic              full_reg;
    logic              m_valid_reg;
    logic [mxt_pkg::DATA_W-1:0] m_best_reg;
    logic              m_full_reg;

    logic              bit_b;
    logic [IDXW-1:0]   child0;
    logic [IDXW-1:0]   child1;
    logic [IDXW-1:0]   child_b;
    logic [IDXW-1:0]   child_w;
    logic [IDXW-1:0]   alloc_idx;
    logic              store_full;
    logic              at_bottom;
    logic              ins_follow;
    logic              ins_alloc;
    logic              ins_stop;
    logic [2*IDXW-1:0] base_entry;
    logic              q_take_w;
    logic              q_dead;
    logic [IDXW-1:0]   q_next;
    logic [WIDTH-1:0]  level_mask;
    logic [WIDTH-1:0]  acc_new;
    logic [WIDTH-1:0]  prefix_new;

    assign bit_b      = key_reg[level_reg];
    assign child0     = rd_data_reg[IDXW-1:0];
    assign child1     = rd_data_reg[2*IDXW-1:IDXW];
    assign child_b    = bit_b ? child1 : child0;
    assign child_w    = bit_b ? child0 : child1;
    assign alloc_idx  = nodes_used_reg[IDXW-1:0];
    assign store_full = (nodes_used_reg == CNTW'(NODE_DEPTH));
    assign at_bottom  = (level_reg == '0);
    assign prefix_new = prefix_reg ^ elem_reg;

    // Insert: follow an existing child, else hang a new node. Once a node is
    // new, everything below it is new too and needs no read.
    assign ins_follow = !fresh_reg && (child_b != '0);
    assign ins_alloc  = !ins_follow && !store_full;
    assign ins_stop   = !ins_follow && store_full;
    assign base_entry = fresh_reg ? '0 : rd_data_reg;
    assign wr_en      = cmd.ins_step && ins_alloc;
    assign wr_data    = bit_b ? {alloc_idx, base_entry[IDXW-1:0]}
                              : {base_entry[2*IDXW-1:IDXW], alloc_idx};

    // Query: prefer the branch opposite to the key bit.
    assign q_take_w   = (child_w != '0);
    assign q_dead     = !q_take_w && (child_b == '0);
    assign q_next     = q_take_w ? child_w : child_b;
    assign level_mask = WIDTH'(1) << level_reg;
    assign acc_new    = q_take_w ? (acc_reg | level_mask) : acc_reg;

    always_comb begin
        priority if (cmd.ins_begin || cmd.qry_begin) begin
            rd_addr = '0;
        end else if (cmd.qry_step) begin
            rd_addr = q_next;
        end else begin
            rd_addr = child_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[cur_reg] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    assign status.start_now = s_first || !started_reg;
    assign status.full_now  = (items_reg >= ITW'(MAX_ITEMS));
    assign status.ins_done  = at_bottom || ins_stop;
    assign status.qry_done  = at_bottom || q_dead;
    assign status.out_free  = !m_valid_reg || m_tready;

    // Array and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            fresh_reg      <= 1'b0;
            nodes_used_reg <= CNTW'(1);
            items_reg      <= '0;
            prefix_reg     <= '0;
            best_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.accept && status.start_now) begin
                started_reg    <= 1'b1;
                fresh_reg      <= 1'b1;
                nodes_used_reg <= CNTW'(1);
                items_reg      <= '0;
                prefix_reg     <= '0;
                best_reg       <= '0;
            end
            if (cmd.set_prefix) begin
                prefix_reg <= prefix_new;
            end
            if (cmd.ins_step) begin
                if (status.ins_done) begin
                    fresh_reg <= 1'b0;
                end else if (ins_alloc) begin
                    fresh_reg <= 1'b1;
                end
                if (ins_alloc) begin
                    nodes_used_reg <= nodes_used_reg + CNTW'(1);
                end
            end
            if (cmd.qry_step && status.qry_done) begin
                if (acc_new > best_reg) begin
                    best_reg <= acc_new;
                end
                items_reg <= items_reg + ITW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            elem_reg <= s_element[WIDTH-1:0];
            full_reg <= !status.start_now && status.full_now;
            key_reg  <= '0;
        end
        if (cmd.set_prefix) begin
            key_reg <= prefix_new;
        end
        if (cmd.ins_begin || cmd.qry_begin) begin
            cur_reg   <= '0;
            level_reg <= LVLW'(WIDTH - 1);
            acc_reg   <= '0;
        end
        if (cmd.ins_step) begin
            level_reg <= level_reg - LVLW'(1);
            if (ins_follow) begin
                cur_reg <= child_b;
            end else if (ins_alloc) begin
                cur_reg <= alloc_idx;
            end
        end
        if (cmd.qry_step) begin
            level_reg <= level_reg - LVLW'(1);
            acc_reg   <= acc_new;
        end
        if (cmd.out_load) begin
            m_best_reg <= mxt_pkg::DATA_W'(best_reg);
            m_full_reg <= full_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_best_xor = m_best_reg;
    assign m_full_res = m_full_reg;

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg <= CNTW'(NODE_DEPTH))
        else $error("node count beyond the node store");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && status.start_now |=> nodes_used_reg == CNTW'(1) && best_reg == '0)
        else $error("new array did not clear trie and best value");

    a_fresh_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_step && status.ins_done |=> !fresh_reg)
        else $error("new-node mode leaked past the end of an insert");

endmodule

`default_nettype wire
